// ===== rtl/aho_pkg.sv =====
// Shared types, register codes and the heatmap ratio table for the heatmap overlay block.
package aho_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int MARK_W     = 8;
    localparam int PIX_W      = 16;
    localparam int VOTE_W     = 4;
    localparam int ALPHA_W    = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIDE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID   = 2'd3;

    localparam logic [1:0] MODE_EITHER = 2'd0;
    localparam logic [1:0] MODE_SP     = 2'd1;

    localparam logic [PIX_W-1:0]   FULL_SCALE = 16'hFFFF;
    localparam logic [ALPHA_W-1:0] ALPHA_ON   = 15'h7FFF;

    typedef struct packed {
        logic              kind;
        logic              frame_start;
        logic [PIX_W-1:0]  intensity;
        logic [MARK_W-1:0] sp_marks;
        logic [MARK_W-1:0] manual_marks;
        logic              grid_bit;
    } t_in_req;

    typedef struct packed {
        logic [PIX_W-1:0]   gray_level;
        logic [VOTE_W-1:0]  vote_count;
        logic [PIX_W-1:0]   heat_red;
        logic [PIX_W-1:0]   heat_green;
        logic [PIX_W-1:0]   heat_blue;
        logic [ALPHA_W-1:0] heat_alpha;
        logic               grid_visible;
    } t_out_req;

    // Controller to datapath.
    typedef struct packed {
        logic accept;
        logic div_start;
        logic emit;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic render;
        logic scale_ok;
        logic div_busy;
        logic out_free;
    } t_sts;

    // floor(65535 * num / den) for den 1..7 and num 0..den.
    function automatic logic [PIX_W-1:0] heat_ratio(input logic [2:0] den,
                                                   input logic [2:0] num);
        logic [PIX_W-1:0] v;
        v = '0;
        case ({den, num})
            6'o11: v = 16'd65535;
            6'o21: v = 16'd32767;
            6'o22: v = 16'd65535;
            6'o31: v = 16'd21845;
            6'o32: v = 16'd43690;
            6'o33: v = 16'd65535;
            6'o41: v = 16'd16383;
            6'o42: v = 16'd32767;
            6'o43: v = 16'd49151;
            6'o44: v = 16'd65535;
            6'o51: v = 16'd13107;
            6'o52: v = 16'd26214;
            6'o53: v = 16'd39321;
            6'o54: v = 16'd52428;
            6'o55: v = 16'd65535;
            6'o61: v = 16'd10922;
            6'o62: v = 16'd21845;
            6'o63: v = 16'd32767;
            6'o64: v = 16'd43690;
            6'o65: v = 16'd54612;
            6'o66: v = 16'd65535;
            6'o71: v = 16'd9362;
            6'o72: v = 16'd18724;
            6'o73: v = 16'd28086;
            6'o74: v = 16'd37448;
            6'o75: v = 16'd46810;
            6'o76: v = 16'd56172;
            6'o77: v = 16'd65535;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/aho_div.sv =====
// Bit-serial restoring divider that forms floor(65535 / divisor), one bit a cycle.
module aho_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [aho_pkg::PIX_W-1:0] i_divisor,
    output logic                      o_busy,
    output logic [aho_pkg::PIX_W-1:0] o_quotient
);
    import aho_pkg::*;

    localparam int CNT_W = $clog2(PIX_W);

    logic             r_busy, n_busy;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [PIX_W-1:0] r_div, n_div;
    logic [PIX_W-1:0] r_rem, n_rem;
    logic [PIX_W-1:0] r_quo, n_quo;
    logic [PIX_W:0]   trial;
    logic             fits;

    // The dividend is all ones, so every shift brings in a one.
    assign trial = {r_rem, 1'b1};
    assign fits  = trial >= {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_div  = r_div;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_div  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_rem = fits ? PIX_W'(trial - {1'b0, r_div}) : trial[PIX_W-1:0];
            n_quo = {r_quo[PIX_W-2:0], fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(PIX_W - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_div <= n_div;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/aho_datapath.sv =====
// Datapath: registers, running maximum, scale divider, vote count, heatmap and output register.
module aho_datapath #(
    parameter int ANNOTATORS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [aho_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [aho_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  aho_pkg::t_in_req               i_in_data,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output aho_pkg::t_out_req              o_out_data,
    input  aho_pkg::t_cmd                  i_cmd,
    output aho_pkg::t_sts                  o_sts
);
    import aho_pkg::*;

    localparam int LANES = (ANNOTATORS < MARK_W) ? ANNOTATORS : MARK_W;

    function automatic logic [VOTE_W-1:0] popcount(input logic [MARK_W-1:0] v);
        logic [VOTE_W-1:0] c;
        c = '0;
        for (int k = 0; k < MARK_W; k++) begin
            c = c + VOTE_W'(v[k]);
        end
        return c;
    endfunction

    logic [MARK_W-1:0] r_enable;
    logic [1:0]        r_mode;
    logic              r_hide;
    logic              r_grid;
    logic [PIX_W-1:0]  r_max, n_max;
    logic              r_scale_ok;
    t_in_req           r_item;
    logic              r_out_valid;
    t_out_req          r_out;

    logic [PIX_W-1:0]  base_max;
    logic              div_busy;
    logic [PIX_W-1:0]  scale;
    logic [MARK_W-1:0] lane_mask;
    logic [MARK_W-1:0] marks;
    logic [MARK_W-1:0] en_lanes;
    logic [VOTE_W-1:0] enabled;
    logic [VOTE_W-1:0] votes;
    logic [2:0]        den;
    logic [4:0]        q;
    logic [4:0]        d2;
    logic [4:0]        d3;
    logic [4:0]        d4;
    logic [2:0]        num;
    logic [PIX_W-1:0]  ratio;
    logic [2*PIX_W-1:0] gray_full;
    t_out_req          res;

    // Frame start drops the maximum to one before the item is applied.
    always_comb begin
        base_max = i_in_data.frame_start ? PIX_W'(1) : r_max;
        n_max    = base_max;
        if (!i_in_data.kind && (i_in_data.intensity > base_max)) begin
            n_max = i_in_data.intensity;
        end
    end

    aho_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_divisor  (n_max),
        .o_busy     (div_busy),
        .o_quotient (scale)
    );

    always_comb begin
        for (int k = 0; k < MARK_W; k++) begin
            lane_mask[k] = (k < LANES);
        end
    end

    always_comb begin
        if (r_mode == MODE_EITHER) begin
            marks = r_item.sp_marks | r_item.manual_marks;
        end else if (r_mode == MODE_SP) begin
            marks = r_item.sp_marks;
        end else begin
            marks = r_item.manual_marks;
        end
    end

    assign en_lanes = r_enable & lane_mask;
    assign enabled  = popcount(en_lanes);
    assign votes    = popcount(en_lanes & marks);
    assign den      = 3'(enabled - 1'b1);
    assign q        = {3'(votes - 1'b1), 2'b00};
    assign d2       = {1'b0, den, 1'b0};
    assign d3       = 5'({2'b00, den} + {1'b0, den, 1'b0});
    assign d4       = {den, 2'b00};

    // Pick the segment; each numerator stays within 0..den.
    always_comb begin
        if (q < 5'(den)) begin
            num = q[2:0];
        end else if (q < d2) begin
            num = 3'(d2 - q);
        end else if (q < d3) begin
            num = 3'(q - d2);
        end else begin
            num = 3'(d4 - q);
        end
    end

    assign ratio     = heat_ratio(den, num);
    assign gray_full = scale * r_item.intensity;

    always_comb begin
        res              = '0;
        res.gray_level   = gray_full[PIX_W-1:0];
        res.vote_count   = votes;
        res.grid_visible = r_item.grid_bit & r_grid;
        if ((votes != '0) && !r_hide) begin
            res.heat_alpha = ALPHA_ON;
            if (enabled <= VOTE_W'(1)) begin
                res.heat_red = FULL_SCALE;
            end else if (q < 5'(den)) begin
                res.heat_green = ratio;
                res.heat_blue  = FULL_SCALE;
            end else if (q < d2) begin
                res.heat_green = FULL_SCALE;
                res.heat_blue  = ratio;
            end else if (q < d3) begin
                res.heat_red   = ratio;
                res.heat_green = FULL_SCALE;
            end else begin
                res.heat_red   = FULL_SCALE;
                res.heat_green = ratio;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 8'hFF;
            r_mode      <= MODE_EITHER;
            r_hide      <= 1'b0;
            r_grid      <= 1'b0;
            r_max       <= PIX_W'(1);
            r_scale_ok  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ENABLE: r_enable <= i_cfg_data;
                    CFG_MODE:   r_mode   <= i_cfg_data[1:0];
                    CFG_HIDE:   r_hide   <= i_cfg_data[0];
                    CFG_GRID:   r_grid   <= i_cfg_data[0];
                    default:    r_enable <= r_enable;
                endcase
            end
            if (i_cmd.accept) begin
                r_max <= n_max;
                if (n_max != r_max) begin
                    r_scale_ok <= 1'b0;
                end
            end
            // Max cannot move while the divider runs, so mark it good at start.
            if (i_cmd.div_start) begin
                r_scale_ok <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_cmd.accept) begin
            r_item <= i_in_data;
        end
        if (i_cmd.emit) begin
            r_out <= res;
        end
    end

    assign o_sts.render   = i_in_data.kind;
    assign o_sts.scale_ok = r_scale_ok && (n_max == r_max);
    assign o_sts.div_busy = div_busy;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/aho_ctrl.sv =====
// Controller: sequences accept, scale division and result hand-off.
module aho_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  aho_pkg::t_sts i_sts,
    output aho_pkg::t_cmd o_cmd
);
    import aho_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.render) begin
                        if (i_sts.scale_ok) begin
                            n_state = ST_EMIT;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            n_state         = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

// ===== rtl/annotation_heatmap_overlay.sv =====
// Top level of the per-pixel heatmap overlay renderer.
// Pixels arrive as requests of two kinds. A measure request folds its intensity
// into the running maximum of the slice and produces nothing. A render request
// produces one result: the gray level floor(65535/max) times the intensity (low
// 16 bits), the number of enabled annotators marking the pixel under the display
// mode, a blue-cyan-green-yellow-red heatmap colour with alpha, and the grid
// flag. While the scale quotient is current a render request goes straight to
// its result; after the running maximum has changed, the bit-serial divider
// first runs its 16 divide steps to rebuild floor(65535/max) before the result
// is formed. Frame start resets the maximum to one before the request is
// applied. The result sits in an output register, so a waiting result does not
// block the next measure request; a render request waits only until the output
// register frees up. Configuration is written through a plain write port; the
// user must write it only while the block is idle, which the block itself does
// not enforce.
module annotation_heatmap_overlay #(
    parameter int ANNOTATORS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [aho_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [aho_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  aho_pkg::t_in_req               i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output aho_pkg::t_out_req              o_out_data
);
    import aho_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequence each request: accept, and for a render request divide when the maximum moved, then emit.
    aho_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Hold registers, the maximum, the divider and the result register.
    aho_datapath #(
        .ANNOTATORS (ANNOTATORS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
